>>> sv/mtcp_pkg.sv
package mtcp_pkg;

    localparam int unsigned DISPLAY_LIMIT = 4;
    localparam int unsigned HEADER_BYTES  = 4;

    localparam logic [31:0] WORD32_ONES = 32'hFFFF_FFFF;
    localparam int unsigned SEL_BYTES   = HEADER_BYTES;
    localparam int unsigned WORD_BITS   = 256;

    // highest offset word value that can be rebased past the selector
    localparam logic [31:0] OFFSET_MAX = WORD32_ONES - 32'(SEL_BYTES);

    localparam logic [4:0]  SHOWN_MAX = 5'(DISPLAY_LIMIT);
    localparam logic [15:0] LIMIT_16  = 16'(DISPLAY_LIMIT);

    localparam logic [1:0] KIND_SINGLE   = 2'd0;
    localparam logic [1:0] KIND_BATCH    = 2'd1;
    localparam logic [1:0] KIND_APPROVAL = 2'd2;
    localparam logic [1:0] KIND_UNSUPP   = 2'd3;

    localparam logic [3:0] ST_NONE     = 4'd0;
    localparam logic [3:0] ST_FROM     = 4'd1;
    localparam logic [3:0] ST_TO       = 4'd2;
    localparam logic [3:0] ST_ID       = 4'd3;
    localparam logic [3:0] ST_VALUE    = 4'd4;
    localparam logic [3:0] ST_IDSOFF   = 4'd5;
    localparam logic [3:0] ST_VALSOFF  = 4'd6;
    localparam logic [3:0] ST_IDSLEN   = 4'd7;
    localparam logic [3:0] ST_VALSLEN  = 4'd8;
    localparam logic [3:0] ST_OPERATOR = 4'd9;
    localparam logic [3:0] ST_APPROVED = 4'd10;

    localparam logic [2:0] CAP_NONE        = 3'd0;
    localparam logic [2:0] CAP_RECIPIENT   = 3'd1;
    localparam logic [2:0] CAP_TOKEN       = 3'd2;
    localparam logic [2:0] CAP_BATCH_ID    = 3'd3;
    localparam logic [2:0] CAP_BATCH_VALUE = 3'd4;
    localparam logic [2:0] CAP_OPERATOR    = 3'd5;

    typedef struct packed {
        logic                 first;
        logic [WORD_BITS-1:0] word;
        logic [31:0]          offset;
    } item_t;

    typedef struct packed {
        logic                 status;
        logic [3:0]           next_step;
        logic [2:0]           capture_kind;
        logic [15:0]          capture_index;
        logic [4:0]           shown_count;
        logic                 truncated;
        logic [7:0]           approved;
        logic [WORD_BITS-1:0] total;
    } result_t;

endpackage

>>> sv/mtcp_in_reg.sv
module mtcp_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mtcp_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output mtcp_pkg::item_t item
);
    import mtcp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/mtcp_core.sv
module mtcp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [1:0]        call_kind,
    input  mtcp_pkg::item_t   item,
    output mtcp_pkg::result_t res
);
    import mtcp_pkg::*;

    logic [3:0]           step_reg, step_next;
    logic [31:0]          ids_start_reg, ids_start_next;
    logic [31:0]          values_start_reg, values_start_next;
    logic [15:0]          ids_left_reg, ids_left_next;
    logic [15:0]          values_left_reg, values_left_next;
    logic [15:0]          entry_index_reg, entry_index_next;
    logic [WORD_BITS-1:0] total_reg, total_next;
    logic [4:0]           shown_reg, shown_next;
    logic                 cut_off_reg, cut_off_next;
    logic [7:0]           approval_reg, approval_next;

    logic [WORD_BITS-1:0] w;
    logic                 off_ok;
    logic [31:0]          off_val;
    logic                 len_ok;
    logic [15:0]          len;
    logic [WORD_BITS:0]   sum;
    logic [15:0]          ids_dec;
    logic [15:0]          vals_dec;
    logic                 status;
    logic [2:0]           cap;
    logic [15:0]          cap_idx;

    assign w       = item.word;
    assign off_ok  = (w[255:32] == '0) && (w[31:0] <= OFFSET_MAX);
    assign off_val = w[31:0] + 32'(SEL_BYTES);
    assign len_ok  = (w[255:16] == '0);
    assign len     = w[15:0];

    always_comb begin
        step_next         = step_reg;
        ids_start_next    = ids_start_reg;
        values_start_next = values_start_reg;
        ids_left_next     = ids_left_reg;
        values_left_next  = values_left_reg;
        entry_index_next  = entry_index_reg;
        total_next        = total_reg;
        shown_next        = shown_reg;
        cut_off_next      = cut_off_reg;
        approval_next     = approval_reg;
        status            = 1'b0;
        cap               = CAP_NONE;
        cap_idx           = '0;

        if (item.first) begin
            ids_start_next    = '0;
            values_start_next = '0;
            ids_left_next     = '0;
            values_left_next  = '0;
            entry_index_next  = '0;
            total_next        = '0;
            shown_next        = '0;
            cut_off_next      = 1'b0;
            approval_next     = '0;
            case (call_kind)
                KIND_APPROVAL: step_next = ST_OPERATOR;
                KIND_UNSUPP:   step_next = ST_NONE;
                default:       step_next = ST_FROM;
            endcase
        end

        // derived from the post-restart state
        sum      = {1'b0, total_next} + {1'b0, w};
        ids_dec  = ids_left_next - 16'd1;
        vals_dec = values_left_next - 16'd1;

        case (call_kind)
            KIND_SINGLE: begin
                case (step_next)
                    ST_FROM: step_next = ST_TO;
                    ST_TO: begin
                        cap       = CAP_RECIPIENT;
                        step_next = ST_ID;
                    end
                    ST_ID: begin
                        cap       = CAP_TOKEN;
                        step_next = ST_VALUE;
                    end
                    ST_VALUE: begin
                        total_next = w;
                        step_next  = ST_NONE;
                    end
                    default: ;
                endcase
            end
            KIND_BATCH: begin
                case (step_next)
                    ST_FROM: step_next = ST_TO;
                    ST_TO: begin
                        cap       = CAP_RECIPIENT;
                        step_next = ST_IDSOFF;
                    end
                    ST_IDSOFF: begin
                        if (off_ok) begin
                            ids_start_next = off_val;
                            step_next      = ST_VALSOFF;
                        end else begin
                            status = 1'b1;
                        end
                    end
                    ST_VALSOFF: begin
                        if (off_ok) begin
                            values_start_next = off_val;
                            step_next         = ST_IDSLEN;
                        end else begin
                            status = 1'b1;
                        end
                    end
                    ST_IDSLEN: begin
                        // word before the array start: skipped
                        if (item.offset >= ids_start_next) begin
                            if (item.offset != ids_start_next || !len_ok) begin
                                status = 1'b1;
                            end else begin
                                ids_left_next    = len;
                                shown_next       = (len > LIMIT_16) ? SHOWN_MAX : len[4:0];
                                cut_off_next     = (len > LIMIT_16);
                                step_next        = (len == '0) ? ST_VALSLEN : ST_ID;
                                entry_index_next = '0;
                            end
                        end
                    end
                    ST_ID: begin
                        if (entry_index_next < LIMIT_16) begin
                            cap     = CAP_BATCH_ID;
                            cap_idx = entry_index_next;
                        end
                        ids_left_next = ids_dec;
                        if (ids_dec == '0) begin
                            step_next = ST_VALSLEN;
                        end
                        entry_index_next = entry_index_next + 16'd1;
                    end
                    ST_VALSLEN: begin
                        if (item.offset >= values_start_next) begin
                            if (item.offset != values_start_next || !len_ok
                                || len != entry_index_next) begin
                                status = 1'b1;
                            end else begin
                                values_left_next = len;
                                step_next        = (len == '0) ? ST_NONE : ST_VALUE;
                                total_next       = '0;
                                entry_index_next = '0;
                            end
                        end
                    end
                    ST_VALUE: begin
                        if (entry_index_next < LIMIT_16) begin
                            cap     = CAP_BATCH_VALUE;
                            cap_idx = entry_index_next;
                        end
                        // wrapped total is kept even on overflow
                        total_next = sum[WORD_BITS-1:0];
                        if (sum[WORD_BITS]) begin
                            status = 1'b1;
                        end else begin
                            values_left_next = vals_dec;
                            if (vals_dec == '0) begin
                                step_next = ST_NONE;
                            end
                            entry_index_next = entry_index_next + 16'd1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_APPROVAL: begin
                case (step_next)
                    ST_OPERATOR: begin
                        cap       = CAP_OPERATOR;
                        step_next = ST_APPROVED;
                    end
                    ST_APPROVED: begin
                        approval_next = w[7:0];
                        step_next     = ST_NONE;
                    end
                    default: status = 1'b1;
                endcase
            end
            default: status = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg         <= ST_FROM;
            ids_start_reg    <= '0;
            values_start_reg <= '0;
            ids_left_reg     <= '0;
            values_left_reg  <= '0;
            entry_index_reg  <= '0;
            total_reg        <= '0;
            shown_reg        <= '0;
            cut_off_reg      <= 1'b0;
            approval_reg     <= '0;
        end else if (en) begin
            step_reg         <= step_next;
            ids_start_reg    <= ids_start_next;
            values_start_reg <= values_start_next;
            ids_left_reg     <= ids_left_next;
            values_left_reg  <= values_left_next;
            entry_index_reg  <= entry_index_next;
            total_reg        <= total_next;
            shown_reg        <= shown_next;
            cut_off_reg      <= cut_off_next;
            approval_reg     <= approval_next;
        end
    end

    always_comb begin
        res.status        = status;
        res.next_step     = step_next;
        res.capture_kind  = cap;
        res.capture_index = cap_idx;
        res.shown_count   = shown_next;
        res.truncated     = cut_off_next;
        res.approved      = approval_next;
        res.total         = total_next;
    end

endmodule

>>> sv/multi_token_call_param_parser_unit.sv
// channel  | ports                          | carries
// ---------+--------------------------------+----------------------------------
// s_       | s_valid/s_ready                | call-data word, offset, first flag
// m_       | m_valid/m_ready                | status, step, capture, totals
// cfg_     | cfg_valid/cfg_ready            | call kind register
//
// One word per cycle sustained while m_ready is high.
// The word goes into an input register, one pass of decode and the 256-bit
// total add updates parser state and loads the result register together.
// Reset (aresetn, synchronous) clears the parser to the from step, kind 0.
// A stalled m_ side holds one result and one buffered word; s_ready then drops.
module multi_token_call_param_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_call_kind,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first,
    input  logic [63:0] s_word_lane3,
    input  logic [63:0] s_word_lane2,
    input  logic [63:0] s_word_lane1,
    input  logic [63:0] s_word_lane0,
    input  logic [31:0] s_word_offset,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [3:0]  m_next_step,
    output logic [2:0]  m_capture_kind,
    output logic [15:0] m_capture_index,
    output logic [4:0]  m_shown_count,
    output logic        m_truncated,
    output logic [7:0]  m_approved,
    output logic [63:0] m_total_lane3,
    output logic [63:0] m_total_lane2,
    output logic [63:0] m_total_lane1,
    output logic [63:0] m_total_lane0
);
    import mtcp_pkg::*;

    logic [1:0] call_kind_reg;
    item_t      s_item;
    item_t      item;
    logic       item_valid;
    logic       take;
    result_t    res;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            call_kind_reg <= KIND_SINGLE;
        end else if (cfg_valid && cfg_ready) begin
            call_kind_reg <= cfg_call_kind;
        end
    end

    assign s_item.first  = s_first;
    assign s_item.word   = {s_word_lane3, s_word_lane2, s_word_lane1, s_word_lane0};
    assign s_item.offset = s_word_offset;

    assign take = item_valid && (!out_valid_reg || m_ready);

    mtcp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mtcp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (take),
        .call_kind (call_kind_reg),
        .item      (item),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = out_reg.status;
    assign m_next_step     = out_reg.next_step;
    assign m_capture_kind  = out_reg.capture_kind;
    assign m_capture_index = out_reg.capture_index;
    assign m_shown_count   = out_reg.shown_count;
    assign m_truncated     = out_reg.truncated;
    assign m_approved      = out_reg.approved;
    assign m_total_lane3   = out_reg.total[255:192];
    assign m_total_lane2   = out_reg.total[191:128];
    assign m_total_lane1   = out_reg.total[127:64];
    assign m_total_lane0   = out_reg.total[63:0];

endmodule

>>> sim/tb_multi_token_call_param_parser_unit.sv
module tb_multi_token_call_param_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mtcp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_call_kind;
    logic        s_valid;
    logic        s_ready;
    logic        s_first;
    logic [63:0] s_word_lane3;
    logic [63:0] s_word_lane2;
    logic [63:0] s_word_lane1;
    logic [63:0] s_word_lane0;
    logic [31:0] s_word_offset;
    logic        m_valid;
    logic        m_ready;
    logic        m_status;
    logic [3:0]  m_next_step;
    logic [2:0]  m_capture_kind;
    logic [15:0] m_capture_index;
    logic [4:0]  m_shown_count;
    logic        m_truncated;
    logic [7:0]  m_approved;
    logic [63:0] m_total_lane3;
    logic [63:0] m_total_lane2;
    logic [63:0] m_total_lane1;
    logic [63:0] m_total_lane0;

    // parser shadow state
    logic [1:0]   kind_q;
    logic [3:0]   pstep;
    logic [31:0]  ids_base;
    logic [31:0]  vals_base;
    logic [15:0]  ids_rem;
    logic [15:0]  vals_rem;
    logic [15:0]  entry_idx;
    logic [255:0] run_total;
    logic [4:0]   shown_n;
    logic         cut_n;
    logic [7:0]   appr_b;

    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;

    multi_token_call_param_parser_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_call_kind   (cfg_call_kind),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first         (s_first),
        .s_word_lane3    (s_word_lane3),
        .s_word_lane2    (s_word_lane2),
        .s_word_lane1    (s_word_lane1),
        .s_word_lane0    (s_word_lane0),
        .s_word_offset   (s_word_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_next_step     (m_next_step),
        .m_capture_kind  (m_capture_kind),
        .m_capture_index (m_capture_index),
        .m_shown_count   (m_shown_count),
        .m_truncated     (m_truncated),
        .m_approved      (m_approved),
        .m_total_lane3   (m_total_lane3),
        .m_total_lane2   (m_total_lane2),
        .m_total_lane1   (m_total_lane1),
        .m_total_lane0   (m_total_lane0)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void count_error(string msg);
        if (error_count < 10) begin
            $display("%0t: %s", $time, msg);
        end
        error_count++;
    endfunction

    function automatic void compare_field(string name, logic [255:0] want, logic [255:0] got);
        if (want !== got) begin
            count_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t exp_r;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                count_error("result word with nothing pending");
            end else begin
                exp_r = pending_results.pop_front();
                compare_field("status", 256'(exp_r.status), 256'(m_status));
                compare_field("next_step", 256'(exp_r.next_step), 256'(m_next_step));
                compare_field("capture_kind", 256'(exp_r.capture_kind),
                              256'(m_capture_kind));
                compare_field("capture_index", 256'(exp_r.capture_index),
                              256'(m_capture_index));
                compare_field("shown_count", 256'(exp_r.shown_count),
                              256'(m_shown_count));
                compare_field("truncated", 256'(exp_r.truncated), 256'(m_truncated));
                compare_field("approved", 256'(exp_r.approved), 256'(m_approved));
                compare_field("total_lane3", 256'(exp_r.total[255:192]),
                              256'(m_total_lane3));
                compare_field("total_lane2", 256'(exp_r.total[191:128]),
                              256'(m_total_lane2));
                compare_field("total_lane1", 256'(exp_r.total[127:64]),
                              256'(m_total_lane1));
                compare_field("total_lane0", 256'(exp_r.total[63:0]),
                              256'(m_total_lane0));
            end
        end
    end

    function automatic void clear_parse();
        pstep = ST_FROM;
        ids_base = '0;
        vals_base = '0;
        ids_rem = '0;
        vals_rem = '0;
        entry_idx = '0;
        run_total = '0;
        shown_n = '0;
        cut_n = 1'b0;
        appr_b = '0;
    endfunction

    function automatic logic offset_ok(logic [255:0] w);
        return (w[255:32] == '0) && (w[31:0] <= OFFSET_MAX);
    endfunction

    // length word of the ids or values array
    function automatic void take_length(input logic [255:0] w, input logic [31:0] off,
                                        input logic [31:0] start, input logic is_ids,
                                        inout logic st);
        logic [15:0] len;
        if (off < start) begin
            return;
        end
        if (off != start || w[255:16] != '0) begin
            st = 1'b1;
            return;
        end
        len = w[15:0];
        if (is_ids) begin
            ids_rem = len;
            shown_n = (len > LIMIT_16) ? SHOWN_MAX : len[4:0];
            cut_n = (len > LIMIT_16);
            pstep = (len == 0) ? ST_VALSLEN : ST_ID;
        end else begin
            if (len != entry_idx) begin
                st = 1'b1;
                return;
            end
            vals_rem = len;
            pstep = (len == 0) ? ST_NONE : ST_VALUE;
            run_total = '0;
        end
        entry_idx = '0;
    endfunction

    function automatic result_t decode_word(logic first_f, logic [255:0] w, logic [31:0] off);
        result_t      r;
        logic [2:0]   cap;
        logic [15:0]  cap_at;
        logic         st;
        logic [256:0] sum;
        cap = CAP_NONE;
        cap_at = '0;
        st = 1'b0;
        if (first_f) begin
            clear_parse();
            if (kind_q == KIND_APPROVAL) begin
                pstep = ST_OPERATOR;
            end else if (kind_q == KIND_UNSUPP) begin
                pstep = ST_NONE;
            end
        end
        case (kind_q)
            KIND_SINGLE: begin
                case (pstep)
                    ST_FROM: pstep = ST_TO;
                    ST_TO: begin
                        cap = CAP_RECIPIENT;
                        pstep = ST_ID;
                    end
                    ST_ID: begin
                        cap = CAP_TOKEN;
                        pstep = ST_VALUE;
                    end
                    ST_VALUE: begin
                        run_total = w;
                        pstep = ST_NONE;
                    end
                    default: ;
                endcase
            end
            KIND_BATCH: begin
                case (pstep)
                    ST_FROM: pstep = ST_TO;
                    ST_TO: begin
                        cap = CAP_RECIPIENT;
                        pstep = ST_IDSOFF;
                    end
                    ST_IDSOFF: begin
                        if (offset_ok(w)) begin
                            ids_base = w[31:0] + 32'(HEADER_BYTES);
                            pstep = ST_VALSOFF;
                        end else begin
                            st = 1'b1;
                        end
                    end
                    ST_VALSOFF: begin
                        if (offset_ok(w)) begin
                            vals_base = w[31:0] + 32'(HEADER_BYTES);
                            pstep = ST_IDSLEN;
                        end else begin
                            st = 1'b1;
                        end
                    end
                    ST_IDSLEN: take_length(w, off, ids_base, 1'b1, st);
                    ST_ID: begin
                        if (entry_idx < LIMIT_16) begin
                            cap = CAP_BATCH_ID;
                            cap_at = entry_idx;
                        end
                        ids_rem = ids_rem - 16'd1;
                        if (ids_rem == 0) begin
                            pstep = ST_VALSLEN;
                        end
                        entry_idx = entry_idx + 16'd1;
                    end
                    ST_VALSLEN: take_length(w, off, vals_base, 1'b0, st);
                    ST_VALUE: begin
                        if (entry_idx < LIMIT_16) begin
                            cap = CAP_BATCH_VALUE;
                            cap_at = entry_idx;
                        end
                        sum = {1'b0, run_total} + {1'b0, w};
                        run_total = sum[255:0];
                        // wrapped total is kept, counters hold
                        if (sum[256]) begin
                            st = 1'b1;
                        end else begin
                            vals_rem = vals_rem - 16'd1;
                            if (vals_rem == 0) begin
                                pstep = ST_NONE;
                            end
                            entry_idx = entry_idx + 16'd1;
                        end
                    end
                    default: ;
                endcase
            end
            KIND_APPROVAL: begin
                case (pstep)
                    ST_OPERATOR: begin
                        cap = CAP_OPERATOR;
                        pstep = ST_APPROVED;
                    end
                    ST_APPROVED: begin
                        appr_b = w[7:0];
                        pstep = ST_NONE;
                    end
                    default: st = 1'b1;
                endcase
            end
            default: st = 1'b1;
        endcase
        r.status = st;
        r.next_step = pstep;
        r.capture_kind = cap;
        r.capture_index = cap_at;
        r.shown_count = shown_n;
        r.truncated = cut_n;
        r.approved = appr_b;
        r.total = run_total;
        return r;
    endfunction

    function automatic logic [255:0] rand_word();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [255:0] bad_offset_word();
        logic [255:0] w;
        if ($urandom_range(0, 1) == 1) begin
            w = rand_word();
            w[$urandom_range(32, 255)] = 1'b1;
        end else begin
            w = 256'(OFFSET_MAX) + 256'($urandom_range(1, 4));
        end
        return w;
    endfunction

    function automatic logic [255:0] bad_length_word();
        logic [255:0] w;
        w = 256'($urandom_range(0, 65535));
        w[$urandom_range(16, 255)] = 1'b1;
        return w;
    endfunction

    // mostly small, sometimes wide enough to wrap the total
    function automatic logic [255:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 256'($urandom());
        end else if (r < 8) begin
            return rand_word();
        end
        return '1;
    endfunction

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(logic first_f, logic [255:0] w, logic [31:0] off);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_first <= first_f;
        s_word_lane3 <= w[255:192];
        s_word_lane2 <= w[191:128];
        s_word_lane1 <= w[127:64];
        s_word_lane0 <= w[63:0];
        s_word_offset <= off;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
        pending_results.push_back(decode_word(first_f, w, off));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic set_call_kind(logic [1:0] k);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_call_kind <= k;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        kind_q = k;
    endtask

    task automatic send_noise();
        send_word(1'($urandom_range(0, 1)), rand_word(), $urandom());
    endtask

    task automatic send_single_call();
        int n;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 4;
        for (int i = 0; i < n; i++) begin
            send_word(i == 0, rand_word(), 32'(4 + 32 * i));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_word(1'b0, rand_word(), $urandom());
        end
    endtask

    task automatic send_approval_call();
        logic [255:0] w;
        send_word(1'b1, rand_word(), 32'd4);
        if ($urandom_range(0, 5) == 0) begin
            return;
        end
        w = rand_word();
        if ($urandom_range(0, 2) == 0) begin
            w[7:0] = 8'($urandom_range(0, 1));
        end
        send_word(1'b0, w, 32'd36);
        if ($urandom_range(0, 3) == 0) begin
            send_word(1'b0, rand_word(), $urandom());
        end
    endtask

    // well-formed batch layout with random content and an occasional flaw
    task automatic send_batch_call();
        int          n;
        int          r;
        int          pad_a;
        int          pad_b;
        int          flaw;
        logic [31:0] ids_at;
        logic [31:0] vals_at;
        r = $urandom_range(0, 9);
        n = (r < 2) ? 0 : (r < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
        pad_a = $urandom_range(0, 2);
        pad_b = $urandom_range(0, 2);
        flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        ids_at = 32'(4 + 128 + 32 * pad_a);
        vals_at = ids_at + 32'(32 * (n + 1 + pad_b));
        send_word(1'b1, rand_word(), 32'd4);
        send_word(1'b0, rand_word(), 32'd36);
        if (flaw == 1) begin
            send_word(1'b0, bad_offset_word(), 32'd68);
        end
        send_word(1'b0, 256'(ids_at - 32'd4), 32'd68);
        if (flaw == 2) begin
            send_word(1'b0, bad_offset_word(), 32'd100);
        end
        send_word(1'b0, 256'(vals_at - 32'd4), 32'd100);
        for (int i = 0; i < pad_a; i++) begin
            send_word(1'b0, rand_word(), 32'(132 + 32 * i));
        end
        if (flaw == 3) begin
            send_word(1'b0, 256'(n), ids_at + 32'd32);
        end
        if (flaw == 4) begin
            send_word(1'b0, bad_length_word(), ids_at);
        end
        send_word(1'b0, 256'(n), ids_at);
        for (int i = 0; i < n; i++) begin
            send_word(1'b0, rand_word(), ids_at + 32'(32 * (i + 1)));
        end
        for (int i = 0; i < pad_b; i++) begin
            send_word(1'b0, rand_word(), ids_at + 32'(32 * (n + 1 + i)));
        end
        if (flaw == 5) begin
            send_word(1'b0, 256'(n + 1), vals_at);
        end
        send_word(1'b0, 256'(n), vals_at);
        for (int i = 0; i < n; i++) begin
            send_word(1'b0, rand_value(), vals_at + 32'(32 * (i + 1)));
        end
    endtask

    task automatic test_single_transfer();
        set_call_kind(KIND_SINGLE);
        send_word(1'b1, '0, 32'd0);
        send_word(1'b0, '1, 32'd36);
        send_word(1'b0, '0, 32'd68);
        send_word(1'b0, '1, 32'd100);
    endtask

    task automatic test_approval();
        set_call_kind(KIND_APPROVAL);
        send_word(1'b1, rand_word(), 32'd4);
        send_word(1'b0, '1, 32'd36);
        // nothing left to parse
        send_word(1'b0, rand_word(), 32'd68);
    endtask

    task automatic test_unsupported_kind();
        set_call_kind(KIND_UNSUPP);
        send_word(1'b1, rand_word(), $urandom());
    endtask

    // entry counters left at zero by the single scheme wrap on a batch entry
    task automatic test_kind_switch();
        set_call_kind(KIND_SINGLE);
        send_word(1'b1, rand_word(), 32'd4);
        send_word(1'b0, rand_word(), 32'd36);
        set_call_kind(KIND_BATCH);
        send_word(1'b0, rand_word(), 32'd68);
        set_call_kind(KIND_SINGLE);
        send_word(1'b0, rand_word(), 32'd68);
        set_call_kind(KIND_BATCH);
        send_word(1'b0, rand_word(), 32'd100);
    endtask

    task automatic test_batch_directed();
        set_call_kind(KIND_BATCH);
        send_word(1'b1, rand_word(), 32'd4);
        send_word(1'b0, rand_word(), 32'd36);
        send_word(1'b0, 256'(32'hFFFF_FFFC), 32'd68);
        send_word(1'b0, 256'(32'h80), 32'd68);
        send_word(1'b0, 256'(OFFSET_MAX), 32'd100);
        send_word(1'b0, rand_word(), 32'h64);
        send_word(1'b0, 256'd5, 32'hA4);
        send_word(1'b0, 256'h1_0000, 32'h84);
        send_word(1'b0, 256'd5, 32'h84);
        for (int i = 0; i < 5; i++) begin
            send_word(1'b0, (i == 0) ? '1 : rand_word(), 32'h84 + 32'(32 * (i + 1)));
        end
        send_word(1'b0, 256'd4, 32'hFFFF_FFFF);
        send_word(1'b0, 256'd5, 32'hFFFF_FFFF);
        send_word(1'b0, '1, 32'd0);
        send_word(1'b0, 256'd1, 32'd0);
    endtask

    task automatic test_random_calls();
        int idle_pct[4];
        int stall_pct[4];
        idle_pct = '{0, 55, 0, 35};
        stall_pct = '{0, 0, 55, 35};
        for (int p = 0; p < 4; p++) begin
            wait_drained();
            src_idle_pct = idle_pct[p];
            snk_stall_pct = stall_pct[p];
            set_call_kind(KIND_BATCH);
            repeat (5) begin
                send_batch_call();
                if ($urandom_range(0, 3) == 0) begin
                    send_noise();
                end
            end
            set_call_kind(KIND_SINGLE);
            repeat (6) begin
                send_single_call();
            end
            set_call_kind(KIND_APPROVAL);
            repeat (6) begin
                send_approval_call();
            end
            set_call_kind(KIND_UNSUPP);
            repeat (4) begin
                send_noise();
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_call_kind <= KIND_SINGLE;
        s_valid <= 1'b0;
        s_first <= 1'b0;
        s_word_lane3 <= '0;
        s_word_lane2 <= '0;
        s_word_lane1 <= '0;
        s_word_lane0 <= '0;
        s_word_offset <= '0;
        m_ready <= 1'b0;
        kind_q = KIND_SINGLE;
        clear_parse();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_single_transfer();
        test_approval();
        test_unsupported_kind();
        test_kind_switch();
        test_batch_directed();
        test_random_calls();

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
